>>> src/slw_pkg.sv
// ----------------------------------------------------------------------------
// slw_pkg
// Shared constants and types for the servo slew limiter.
// ----------------------------------------------------------------------------
package slw_pkg;

    localparam int SLOTS          = 5;
    localparam int NUM_CHANNELS_DEF = 5;
    localparam int ANGLE_W        = 8;
    localparam int STEP_W         = 2;
    localparam int IDX_W          = 3;
    localparam int REQ_W          = 16;
    localparam int IVL_W          = 8;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX      = 8'd180;
    localparam logic [ANGLE_W-1:0] START_ANGLE    = 8'd90;
    localparam logic [ANGLE_W-1:0] FAR_LIMIT      = 8'd50;
    localparam logic [ANGLE_W-1:0] MID_LIMIT      = 8'd20;
    localparam logic [IVL_W-1:0]   INTERVAL_RESET = 8'd15;

    localparam logic [STEP_W-1:0] STEP_FAR  = 2'd3;
    localparam logic [STEP_W-1:0] STEP_MID  = 2'd2;
    localparam logic [STEP_W-1:0] STEP_NEAR = 2'd1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    typedef struct packed {
        logic               tick_en;
        logic               set_en;
        logic [ANGLE_W-1:0] angle;
    } chan_cmd_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               moving;
        logic               wrote;
    } chan_stat_t;

endpackage

>>> src/slw_channel.sv
// ----------------------------------------------------------------------------
// slw_channel
// State and update of one servo channel: retarget, tick count,
// bounded step toward the target.
// ----------------------------------------------------------------------------
module slw_channel (
    input  logic                         clk,
    input  logic                         rst_n,
    input  slw_pkg::chan_cmd_t           cmd,
    input  logic [slw_pkg::IVL_W-1:0]    interval,
    output slw_pkg::chan_stat_t          stat
);
    import slw_pkg::*;

    logic [ANGLE_W-1:0] cur_reg, cur_next;
    logic [ANGLE_W-1:0] tgt_reg, tgt_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IVL_W-1:0]   elapsed_reg, elapsed_next;
    logic               moving_reg, moving_next;
    logic               wrote;
    logic [ANGLE_W-1:0] span;
    logic [ANGLE_W:0]   sum;
    logic [ANGLE_W-1:0] diff;

    always_comb
    begin
        cur_next     = cur_reg;
        tgt_next     = tgt_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        moving_next  = moving_reg;
        wrote        = 1'b0;
        span = (cmd.angle >= cur_reg) ? (cmd.angle - cur_reg) : (cur_reg - cmd.angle);
        sum  = {1'b0, cur_reg} + {{(ANGLE_W-STEP_W+1){1'b0}}, step_reg};
        diff = cur_reg - tgt_reg;

        // retarget only on a new value
        if (cmd.set_en && (cmd.angle != tgt_reg))
        begin
            tgt_next    = cmd.angle;
            moving_next = 1'b1;
            if (span > FAR_LIMIT)
                step_next = STEP_FAR;
            else if (span > MID_LIMIT)
                step_next = STEP_MID;
            else
                step_next = STEP_NEAR;
        end

        if (cmd.tick_en)
        begin
            elapsed_next = (elapsed_reg >= interval) ? interval : elapsed_reg + 8'd1;
            if (moving_reg && (elapsed_next == interval))
            begin
                elapsed_next = '0;
                wrote        = 1'b1;
                if (cur_reg < tgt_reg)
                    cur_next = (sum > {1'b0, tgt_reg}) ? tgt_reg : sum[ANGLE_W-1:0];
                else if (cur_reg > tgt_reg)
                    cur_next = (diff > {{(ANGLE_W-STEP_W){1'b0}}, step_reg})
                             ? cur_reg - {{(ANGLE_W-STEP_W){1'b0}}, step_reg}
                             : tgt_reg;
                moving_next = (cur_next != tgt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= START_ANGLE;
            tgt_reg     <= START_ANGLE;
            step_reg    <= STEP_NEAR;
            elapsed_reg <= '0;
            moving_reg  <= 1'b0;
        end
        else
        begin
            cur_reg     <= cur_next;
            tgt_reg     <= tgt_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
            moving_reg  <= moving_next;
        end
    end

    assign stat.angle  = cur_next;
    assign stat.moving = moving_next;
    assign stat.wrote  = wrote;

endmodule

>>> src/servo_slew_limiter.sv
// ----------------------------------------------------------------------------
// servo_slew_limiter
// Up to five servo channels slewing toward their targets at a limited rate.
//
// Input beats (s_*): a tick beat (s_tuser = 0) advances every channel by one
// millisecond; a set beat (s_tuser = 1) gives channel s_tdata[2:0] a new
// target s_tdata[18:3], clamped to 0..180 degrees.
// Output beats (m_*): one per input beat, with all angles, the moving mask
// and the mask of channels that stepped on that tick.
// cfg_wen/cfg_wdata load the step interval; write it only while idle.
// The input register takes a beat at the accepting edge; the channel update
// goes into the result register, and the result is valid, once the output can accept it.
// Throughput: one beat per cycle while the output is not stalled; the channel
// update is a single pass of compare and add logic per channel.
// Reset: angles and targets go to 90, all channels idle, interval 15.
// Stall: when m_tready is low the result holds, the input register takes one
// more beat if it is empty, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module servo_slew_limiter #(
    parameter int NUM_CHANNELS = slw_pkg::NUM_CHANNELS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // servo_index[2:0], target_angle[18:3]
    input  logic                      s_tuser,   // op
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [55:0]               m_tdata,   // angle_0..angle_4[39:0],
                                                 // moving_mask[44:40], write_mask[49:45]
    input  logic                      cfg_wen,
    input  logic [slw_pkg::IVL_W-1:0] cfg_wdata
);
    import slw_pkg::*;

    logic                    in_valid_reg;
    logic                    in_op_reg;
    logic [IDX_W-1:0]        in_idx_reg;
    logic signed [REQ_W-1:0] in_req_reg;
    logic                    out_valid_reg;
    logic [ANGLE_W-1:0]      out_angle_reg [SLOTS];
    logic [SLOTS-1:0]        out_moving_reg;
    logic [SLOTS-1:0]        out_write_reg;
    logic [IVL_W-1:0]        interval_reg;
    logic                    adv;
    logic [ANGLE_W-1:0]      clamped;
    chan_stat_t              stat [SLOTS];

    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_comb
    begin
        if (in_req_reg < 0)
            clamped = '0;
        else if (in_req_reg > $signed({{(REQ_W-ANGLE_W){1'b0}}, ANGLE_MAX}))
            clamped = ANGLE_MAX;
        else
            clamped = in_req_reg[ANGLE_W-1:0];
    end

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_ch
            if (i < NUM_CHANNELS)
            begin : g_on
                chan_cmd_t cmd;
                assign cmd.tick_en = adv && (in_op_reg == OP_TICK);
                assign cmd.set_en  = adv && (in_op_reg == OP_SET)
                                   && (in_idx_reg == IDX_W'(i));
                assign cmd.angle   = clamped;
                slw_channel u_ch (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .cmd      (cmd),
                    .interval (interval_reg),
                    .stat     (stat[i])
                );
            end
            else
            begin : g_off
                assign stat[i] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            interval_reg <= INTERVAL_RESET;
        else if (cfg_wen)
            interval_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg  <= s_tuser;
            in_idx_reg <= s_tdata[IDX_W-1:0];
            in_req_reg <= s_tdata[IDX_W+REQ_W-1:IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                out_angle_reg[k]  <= stat[k].angle;
                out_moving_reg[k] <= stat[k].moving;
                out_write_reg[k]  <= stat[k].wrote;
            end
        end
    end

    always_comb
    begin
        m_tdata = '0;
        for (int k = 0; k < SLOTS; k++)
            m_tdata[k*ANGLE_W +: ANGLE_W] = out_angle_reg[k];
        m_tdata[SLOTS*ANGLE_W +: SLOTS]         = out_moving_reg;
        m_tdata[SLOTS*ANGLE_W + SLOTS +: SLOTS] = out_write_reg;
    end

    assign m_tvalid = out_valid_reg;

    a_set_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        adv && (in_op_reg == OP_SET) |=> out_write_reg == '0)
        else $error("set beat reported a stepped channel");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input held off without a stalled result");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_angle_reg[0] <= ANGLE_MAX) && (out_angle_reg[1] <= ANGLE_MAX)
            && (out_angle_reg[2] <= ANGLE_MAX) && (out_angle_reg[3] <= ANGLE_MAX)
            && (out_angle_reg[4] <= ANGLE_MAX))
        else $error("angle beyond limit");

endmodule
